// ===== design/lbc_pkg.sv =====
// lbc_pkg: shared types and constants for the block buffer cache tag controller
// no dependencies; imported by lru_block_buffer_cache_tags and lbc_order
package lbc_pkg;

	localparam int DEV_W = 8;
	localparam int BLK_W = 32;
	localparam int TAG_W = DEV_W + BLK_W;

	typedef enum logic [1:0] {
		ACT_GET       = 2'd0,
		ACT_WRITE     = 2'd1,
		ACT_RELEASE   = 2'd2,
		ACT_DISK_DONE = 2'd3
	} action_t;

	typedef struct packed {
		action_t            action;
		logic [DEV_W-1:0]   device_id;
		logic [BLK_W-1:0]   block_number;
		logic [3:0]         buffer_index;
	} req_t;

	typedef struct packed {
		logic [3:0] slot;
		logic       hit;
		logic       disk_read;
		logic       disk_write;
		logic       no_buffer;
	} rsp_t;

endpackage

// ===== design/lru_block_buffer_cache_tags.sv =====
// lru_block_buffer_cache_tags: tag and lru replacement controller for disk block buffers
// depends on lbc_pkg, lbc_ram (tag store) and lbc_order (recency order)
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------
//  request | start, busy           | req  (action, device, block, index)
//  result  | done (one cycle)      | rsp  (slot, hit, disk_read/write, no_buffer)
//
// write, disk done and release with out-of-range index: result in the cycle after the transfer
// release: the order walks from position 0 to p, the slot's position, and moves the slot to the front
// get: one recency position a cycle, a hit at position p answers after its tag read and compare,
//   a miss scans all positions for a hit and then walks back from the last one for a victim
// the recency order has a single read position, shared by the get scans and the release walk
// reset clears flags and restores the order; results cannot be stalled
module lru_block_buffer_cache_tags #(
	parameter int NUM_BUFFERS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  lbc_pkg::req_t req,
	output logic          busy,
	output logic          done,
	output lbc_pkg::rsp_t rsp
);
	import lbc_pkg::*;

	localparam int SW = $clog2(NUM_BUFFERS);
	localparam logic [SW-1:0] LAST = SW'(NUM_BUFFERS - 1);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_HSCAN = 4'b0010,
		ST_VSCAN = 4'b0100,
		ST_MOVE  = 4'b1000
	} state_t;

	state_t           state_q, state_d;
	logic [NUM_BUFFERS-1:0] present_q, busy_f_q, valid_q, dirty_q;
	logic [SW-1:0]    pos_q;
	logic             iss_q;
	logic             chk_s1;
	logic             last_s1;
	logic [SW-1:0]    slot_s1;
	logic [TAG_W-1:0] tag_q;
	logic [3:0]       idx_q;
	logic             done_q;
	rsp_t             rsp_q, rsp_d;
	logic             emit;

	logic             idx_ok;
	logic [SW-1:0]    idx_slot;
	logic [SW-1:0]    ord_slot;
	logic             mv_start, mv_done;
	logic [TAG_W-1:0] ram_rdata;
	logic             ram_we;
	logic             match;
	logic             victim_ok;
	logic             accept;

	assign accept   = start && (state_q == ST_IDLE);
	assign idx_ok   = 32'(req.buffer_index) < 32'(NUM_BUFFERS);
	assign idx_slot = SW'(req.buffer_index);

	lbc_order #(.NUM_BUFFERS(NUM_BUFFERS)) u_order (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_pos   (pos_q),
		.rd_slot  (ord_slot),
		.mv_start (mv_start),
		.mv_slot  (idx_slot),
		.mv_done  (mv_done)
	);

	lbc_ram #(.WIDTH(TAG_W), .DEPTH(NUM_BUFFERS)) u_tags (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ord_slot),
		.wdata (tag_q),
		.raddr (ord_slot),
		.rdata (ram_rdata)
	);

	// tag compare in the cycle after the read it belongs to
	assign match     = chk_s1 && present_q[slot_s1] && (ram_rdata == tag_q);
	assign victim_ok = !busy_f_q[ord_slot] && !dirty_q[ord_slot];
	assign ram_we    = (state_q == ST_VSCAN) && victim_ok;

	always_comb begin
		state_d  = state_q;
		emit     = 1'b0;
		rsp_d    = '0;
		mv_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (req.action)
						ACT_GET: begin
							state_d = ST_HSCAN;
						end
						ACT_WRITE: begin
							emit             = 1'b1;
							rsp_d.slot       = req.buffer_index;
							rsp_d.disk_write = idx_ok;
						end
						ACT_RELEASE: begin
							rsp_d.slot = req.buffer_index;
							if (idx_ok) begin
								mv_start = 1'b1;
								state_d  = ST_MOVE;
							end else begin
								emit = 1'b1;
							end
						end
						default: begin
							emit       = 1'b1;
							rsp_d.slot = req.buffer_index;
						end
					endcase
				end
			end
			ST_HSCAN: begin
				if (match) begin
					emit            = 1'b1;
					rsp_d.slot      = 4'(slot_s1);
					rsp_d.hit       = 1'b1;
					rsp_d.disk_read = !valid_q[slot_s1];
					state_d         = ST_IDLE;
				end else if (chk_s1 && last_s1) begin
					state_d = ST_VSCAN;
				end
			end
			ST_VSCAN: begin
				if (victim_ok) begin
					emit            = 1'b1;
					rsp_d.slot      = 4'(ord_slot);
					rsp_d.disk_read = 1'b1;
					state_d         = ST_IDLE;
				end else if (pos_q == '0) begin
					emit            = 1'b1;
					rsp_d.no_buffer = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			ST_MOVE: begin
				if (mv_done) begin
					emit       = 1'b1;
					rsp_d.slot = idx_q;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			present_q <= '0;
			busy_f_q  <= '0;
			valid_q   <= '0;
			dirty_q   <= '0;
			pos_q     <= '0;
			iss_q     <= 1'b0;
			chk_s1    <= 1'b0;
			last_s1   <= 1'b0;
			slot_s1   <= '0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= emit;
			chk_s1  <= (state_q == ST_HSCAN) && iss_q && !match;
			slot_s1 <= ord_slot;
			last_s1 <= (pos_q == LAST);
			case (state_q)
				ST_IDLE: begin
					if (start && idx_ok) begin
						case (req.action)
							ACT_WRITE: begin
								dirty_q[idx_slot] <= 1'b1;
							end
							ACT_RELEASE: begin
								busy_f_q[idx_slot] <= 1'b0;
							end
							ACT_DISK_DONE: begin
								valid_q[idx_slot] <= 1'b1;
								dirty_q[idx_slot] <= 1'b0;
							end
							default: begin
							end
						endcase
					end
					if (start && (req.action == ACT_GET)) begin
						pos_q <= '0;
						iss_q <= 1'b1;
					end
				end
				ST_HSCAN: begin
					if (match) begin
						busy_f_q[slot_s1] <= 1'b1;
						iss_q             <= 1'b0;
					end else if (chk_s1 && last_s1) begin
						pos_q <= LAST;
					end else if (iss_q) begin
						pos_q <= pos_q + SW'(1);
						iss_q <= (pos_q != LAST);
					end
				end
				ST_VSCAN: begin
					if (victim_ok) begin
						present_q[ord_slot] <= 1'b1;
						busy_f_q[ord_slot]  <= 1'b1;
						valid_q[ord_slot]   <= 1'b0;
						dirty_q[ord_slot]   <= 1'b0;
					end else if (pos_q != '0) begin
						pos_q <= pos_q - SW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept && (req.action == ACT_GET)) begin
			tag_q <= {req.device_id, req.block_number};
		end
		if (accept && (req.action == ACT_RELEASE)) begin
			idx_q <= req.buffer_index;
		end
		if (emit) begin
			rsp_q <= rsp_d;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

`ifndef SYNTHESIS
	a_hit_nobuf_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(rsp.hit && rsp.no_buffer))
		else $error("hit and no_buffer in one result");

	a_write_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.disk_write) |-> (!rsp.hit && !rsp.disk_read && !rsp.no_buffer))
		else $error("disk write result carries get flags");

	a_simple_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (req.action == ACT_WRITE || req.action == ACT_DISK_DONE))
		|=> (done && !busy))
		else $error("write or disk done transfer gave no result next cycle");

	a_done_follows_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start)))
		else $error("result without a transfer");
`endif

endmodule

// ===== design/lbc_ram.sv =====
// lbc_ram: generic single write port ram with one registered read port
// no dependencies; storage has no reset
module lbc_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/lbc_order.sv =====
// lbc_order: recency order of the buffer slots, position 0 most recently used
// depends on lbc_pkg; one read position, move-to-front walks one position a cycle
module lbc_order #(
	parameter int NUM_BUFFERS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [$clog2(NUM_BUFFERS)-1:0] rd_pos,
	output logic [$clog2(NUM_BUFFERS)-1:0] rd_slot,
	input  logic                           mv_start,
	input  logic [$clog2(NUM_BUFFERS)-1:0] mv_slot,
	output logic                           mv_done
);
	import lbc_pkg::*;

	localparam int SW = $clog2(NUM_BUFFERS);
	localparam logic [SW-1:0] LAST = SW'(NUM_BUFFERS - 1);

	logic [SW-1:0] ord_q [NUM_BUFFERS];
	logic          mv_act_q;
	logic [SW-1:0] mv_pos_q;
	logic [SW-1:0] mv_carry_q;
	logic [SW-1:0] mv_slot_q;
	logic [SW-1:0] addr;

	assign addr    = mv_act_q ? mv_pos_q : rd_pos;
	assign rd_slot = ord_q[addr];
	// the walk ends where the old copy of the slot sat, or at the last position
	assign mv_done = mv_act_q && ((rd_slot == mv_slot_q) || (mv_pos_q == LAST));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BUFFERS; i++) begin
				ord_q[i] <= SW'(NUM_BUFFERS - 1 - i);
			end
			mv_act_q   <= 1'b0;
			mv_pos_q   <= '0;
			mv_carry_q <= '0;
			mv_slot_q  <= '0;
		end else if (mv_start) begin
			mv_act_q   <= 1'b1;
			mv_pos_q   <= '0;
			mv_carry_q <= mv_slot;
			mv_slot_q  <= mv_slot;
		end else if (mv_act_q) begin
			// shift one entry down towards the old position of the slot
			ord_q[mv_pos_q] <= mv_carry_q;
			mv_carry_q      <= rd_slot;
			mv_pos_q        <= mv_pos_q + SW'(1);
			if (mv_done) begin
				mv_act_q <= 1'b0;
			end
		end
	end

endmodule
